// ===== src/esd_pkg.sv =====
// Shared types, character constants and a helper function for the escape sequence decoder.
package esd_pkg;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_last;
    } text_item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        out_last;
    } dec_item_t;

    typedef struct packed {
        logic      emit;
        dec_item_t item;
    } dec_result_t;

    typedef struct packed {
        logic idle;
        logic emit;
    } dec_status_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_HEX    = 3'b100
    } mode_t;

    localparam logic [15:0] CHAR_BACKSLASH = 16'h005C;
    localparam logic [15:0] CHAR_A_LOWER   = 16'h0061;
    localparam logic [15:0] CHAR_B_LOWER   = 16'h0062;
    localparam logic [15:0] CHAR_F_LOWER   = 16'h0066;
    localparam logic [15:0] CHAR_N_LOWER   = 16'h006E;
    localparam logic [15:0] CHAR_R_LOWER   = 16'h0072;
    localparam logic [15:0] CHAR_T_LOWER   = 16'h0074;
    localparam logic [15:0] CHAR_V_LOWER   = 16'h0076;
    localparam logic [15:0] CHAR_X_LOWER   = 16'h0078;
    localparam logic [15:0] CHAR_U_LOWER   = 16'h0075;

    localparam logic [15:0] CTRL_BEL = 16'd7;
    localparam logic [15:0] CTRL_BS  = 16'd8;
    localparam logic [15:0] CTRL_HT  = 16'd9;
    localparam logic [15:0] CTRL_LF  = 16'd10;
    localparam logic [15:0] CTRL_VT  = 16'd11;
    localparam logic [15:0] CTRL_FF  = 16'd12;
    localparam logic [15:0] CTRL_CR  = 16'd13;

    localparam logic [2:0] DIGITS_X = 3'd2;
    localparam logic [2:0] DIGITS_U = 3'd4;

    // Returns {valid, value} for one code unit taken as a hex digit.
    function automatic logic [4:0] hex_digit(input logic [15:0] u);
        logic [4:0] r;
        r = 5'd0;
        if (u >= 16'h0030 && u <= 16'h0039) begin
            r = {1'b1, 4'(u - 16'h0030)};
        end
        else if (u >= 16'h0041 && u <= 16'h0046) begin
            r = {1'b1, 4'(u - 16'h0041 + 16'd10)};
        end
        else if (u >= 16'h0061 && u <= 16'h0066) begin
            r = {1'b1, 4'(u - 16'h0061 + 16'd10)};
        end
        return r;
    endfunction

endpackage

// ===== src/esd_decode.sv =====
// Decoder state registers and the single-step escape decode logic.
module esd_decode
    import esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  text_item_t  item,
    output dec_result_t result,
    output dec_status_t status
);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [2:0]  digits_left_reg;
    logic [2:0]  digits_left_next;
    logic [15:0] hex_value_reg;
    logic [15:0] hex_value_next;
    logic        hex_bad_reg;
    logic        hex_bad_next;

    logic [4:0]  digit;
    logic [15:0] gathered;
    logic        bad;

    always_comb
    begin
        digit    = hex_digit(item.code_unit);
        gathered = digit[4] ? {hex_value_reg[11:0], digit[3:0]} : hex_value_reg;
        bad      = hex_bad_reg | ~digit[4];

        mode_next        = mode_reg;
        digits_left_next = digits_left_reg;
        hex_value_next   = hex_value_reg;
        hex_bad_next     = hex_bad_reg;
        result.emit          = 1'b0;
        result.item.out_unit = item.code_unit;
        result.item.out_last = item.is_last;

        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_next   = MODE_NORMAL;
                result.emit = 1'b1;
                unique case (item.code_unit)
                    CHAR_A_LOWER: result.item.out_unit = CTRL_BEL;
                    CHAR_B_LOWER: result.item.out_unit = CTRL_BS;
                    CHAR_F_LOWER: result.item.out_unit = CTRL_FF;
                    CHAR_N_LOWER: result.item.out_unit = CTRL_LF;
                    CHAR_R_LOWER: result.item.out_unit = CTRL_CR;
                    CHAR_T_LOWER: result.item.out_unit = CTRL_HT;
                    CHAR_V_LOWER: result.item.out_unit = CTRL_VT;
                    CHAR_X_LOWER, CHAR_U_LOWER:
                    begin
                        result.item.out_unit = CHAR_BACKSLASH;
                        if (!item.is_last) begin
                            result.emit      = 1'b0;
                            mode_next        = MODE_HEX;
                            digits_left_next = (item.code_unit == CHAR_X_LOWER) ?
                                               DIGITS_X : DIGITS_U;
                            hex_value_next   = 16'd0;
                            hex_bad_next     = 1'b0;
                        end
                    end
                    default: result.item.out_unit = CHAR_BACKSLASH;
                endcase
            end
            MODE_HEX:
            begin
                if (digits_left_reg <= 3'd1 || item.is_last) begin
                    result.emit          = 1'b1;
                    result.item.out_unit = bad ? 16'd0 : gathered;
                    mode_next            = MODE_NORMAL;
                    digits_left_next     = 3'd0;
                    hex_value_next       = 16'd0;
                    hex_bad_next         = 1'b0;
                end
                else begin
                    digits_left_next = digits_left_reg - 3'd1;
                    hex_value_next   = gathered;
                    hex_bad_next     = bad;
                end
            end
            default:
            begin
                mode_next   = MODE_NORMAL;
                result.emit = 1'b1;
                if (item.code_unit == CHAR_BACKSLASH && !item.is_last) begin
                    result.emit = 1'b0;
                    mode_next   = MODE_ESCAPE;
                end
            end
        endcase

        status.emit = result.emit;
        status.idle = (mode_reg == MODE_NORMAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= MODE_NORMAL;
            digits_left_reg <= 3'd0;
            hex_value_reg   <= 16'd0;
            hex_bad_reg     <= 1'b0;
        end
        else if (step) begin
            mode_reg        <= mode_next;
            digits_left_reg <= digits_left_next;
            hex_value_reg   <= hex_value_next;
            hex_bad_reg     <= hex_bad_next;
        end
    end

endmodule

// ===== src/escape_sequence_decoder.sv =====
// Top level of the backslash escape decoder: input register, decode step, result register.
//
// The text channel (text_valid, text_stall, text_item) carries one 16-bit code
// unit per request, with is_last marking the end of a string. The decoded
// channel (dec_valid, dec_stall, dec_item) returns zero or one unit for each
// accepted request, in order, with out_last marking the end of the string.
// A request is taken when valid is high and stall is low at a clock edge.
// Each request is held in the input register, is decoded in one pass
// against the decoder state, and any result lands in the result register,
// from which it is offered to the receiver.
// Throughput is one request per cycle while the receiver does not stall, set
// by the single decode step that updates the escape state for each request.
// When the receiver stalls with a result waiting, the decode step halts and
// the input register holds its request; text_stall rises only while both
// registers are occupied.
// Reset clears both registers and returns the decoder to plain text mode.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  text_item_t text_item,
    output logic       dec_valid,
    input  logic       dec_stall,
    output dec_item_t  dec_item
);

    logic        in_valid_reg;
    logic        in_valid_next;
    text_item_t  in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_item_t   out_item_reg;

    logic        advance;
    logic        step;
    dec_result_t result;
    dec_status_t status;

    assign advance    = ~out_valid_reg | ~dec_stall;
    assign step       = in_valid_reg & advance;
    assign text_stall = in_valid_reg & ~advance;

    esd_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (result),
        .status (status)
    );

    always_comb
    begin
        in_valid_next  = text_stall ? in_valid_reg : text_valid;
        out_valid_next = advance ? (step & status.emit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall) begin
            in_item_reg <= text_item;
        end
        if (step && result.emit) begin
            out_item_reg <= result.item;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec_item  = out_item_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (dec_valid && dec_stall))
        else $error("text_stall raised while the result register could drain");

    a_result_held_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(dec_valid) |-> $past(!dec_stall))
        else $error("pending result dropped while stalled");

    a_end_of_string_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_item_reg.is_last) |=> status.idle)
        else $error("decoder not in plain text mode after end of string");

    a_last_always_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_item_reg.is_last) |-> status.emit)
        else $error("end of string produced no result");

endmodule

// ===== test/esd_decode_checker.sv =====
// Checker for the escape sequence decoder: predicts each decoded unit and compares it on arrival.
module esd_decode_checker
    import esd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    input  logic       text_stall,
    input  text_item_t text_item,
    input  logic       dec_valid,
    input  logic       dec_stall,
    input  dec_item_t  dec_item,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    mode_t       mode;
    logic [2:0]  digits;
    logic [15:0] acc;
    logic        bad;
    dec_item_t   expected_units [$];

    function automatic logic decode_unit(input text_item_t t, output dec_item_t r);
        logic [3:0] nib;
        logic       is_hex;
        logic       emit;
        emit = 1'b1;
        r.out_unit = t.code_unit;
        r.out_last = t.is_last;
        case (mode)
            MODE_ESCAPE:
            begin
                mode = MODE_NORMAL;
                case (t.code_unit)
                    CHAR_A_LOWER: r.out_unit = CTRL_BEL;
                    CHAR_B_LOWER: r.out_unit = CTRL_BS;
                    CHAR_F_LOWER: r.out_unit = CTRL_FF;
                    CHAR_N_LOWER: r.out_unit = CTRL_LF;
                    CHAR_R_LOWER: r.out_unit = CTRL_CR;
                    CHAR_T_LOWER: r.out_unit = CTRL_HT;
                    CHAR_V_LOWER: r.out_unit = CTRL_VT;
                    CHAR_X_LOWER, CHAR_U_LOWER:
                    begin
                        if (t.is_last)
                        begin
                            r.out_unit = CHAR_BACKSLASH;
                        end
                        else
                        begin
                            emit = 1'b0;
                            mode = MODE_HEX;
                            digits = (t.code_unit == CHAR_X_LOWER) ? DIGITS_X : DIGITS_U;
                            acc = '0;
                            bad = 1'b0;
                        end
                    end
                    default: r.out_unit = CHAR_BACKSLASH;
                endcase
            end
            MODE_HEX:
            begin
                is_hex = (t.code_unit >= 16'h0030 && t.code_unit <= 16'h0039);
                nib = t.code_unit[3:0];
                if ((t.code_unit >= 16'h0041 && t.code_unit <= 16'h0046) ||
                    (t.code_unit >= 16'h0061 && t.code_unit <= 16'h0066))
                begin
                    is_hex = 1'b1;
                    nib = t.code_unit[3:0] + 4'd9;
                end
                if (is_hex)
                begin
                    acc = {acc[11:0], nib};
                end
                else
                begin
                    bad = 1'b1;
                end
                if (digits <= 3'd1 || t.is_last)
                begin
                    r.out_unit = bad ? 16'h0000 : acc;
                    mode = MODE_NORMAL;
                    digits = '0;
                    acc = '0;
                    bad = 1'b0;
                end
                else
                begin
                    emit = 1'b0;
                    digits = digits - 3'd1;
                end
            end
            default:
            begin
                mode = MODE_NORMAL;
                if (t.code_unit == CHAR_BACKSLASH && !t.is_last)
                begin
                    emit = 1'b0;
                    mode = MODE_ESCAPE;
                end
            end
        endcase
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dec_item_t want;
        if (!rst_n)
        begin
            mode = MODE_NORMAL;
            digits = '0;
            acc = '0;
            bad = 1'b0;
            mismatches = 0;
            expected_units.delete();
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                if (decode_unit(text_item, want))
                begin
                    expected_units.push_back(want);
                end
            end
            if (dec_valid && !dec_stall)
            begin
                if (expected_units.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("decoded unit with none expected: got %h last %b",
                                 dec_item.out_unit, dec_item.out_last);
                    end
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (dec_item.out_unit !== want.out_unit ||
                        dec_item.out_last !== want.out_last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("decoded unit mismatch: expected %h last %b, got %h last %b",
                                     want.out_unit, want.out_last,
                                     dec_item.out_unit, dec_item.out_last);
                        end
                    end
                end
            end
        end
        outstanding = expected_units.size();
    end

endmodule

// ===== test/tb_escape_sequence_decoder.sv =====
// Testbench top for the escape sequence decoder: clock, reset, request and stall stimulus, verdict.
module tb_escape_sequence_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_PCT     = 16;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_stall;
    text_item_t text_item = '0;
    logic       dec_valid;
    logic       dec_stall = 1'b0;
    dec_item_t  dec_item;
    int         mismatches;
    int         outstanding;

    text_item_t  stim_q [$];
    logic [15:0] esc_letters [0:6];
    int          sent = 0;
    int          cycles = 0;
    logic        quiet;

    assign quiet = (sent >= QUIET_FROM && sent < QUIET_TO);

    escape_sequence_decoder dut (.*);

    esd_decode_checker checker_i (.*);

    function automatic void add_unit(input logic [15:0] u, input logic l);
        text_item_t t;
        t.code_unit = u;
        t.is_last = l;
        stim_q.push_back(t);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        dec_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_escape_sequence_decoder: errors");
            $finish;
        end
    end

    initial
    begin
        int          k;
        int          pick;
        int          ndig;
        int          first;
        int          drop;
        int          target;
        logic [15:0] unit;

        esc_letters = '{CHAR_A_LOWER, CHAR_B_LOWER, CHAR_F_LOWER, CHAR_N_LOWER,
                        CHAR_R_LOWER, CHAR_T_LOWER, CHAR_V_LOWER};

        // Every control escape, then the unknown escape, hex escapes and the cut-short endings.
        for (k = 0; k < 7; k++)
        begin
            add_unit(CHAR_BACKSLASH, 1'b0);
            add_unit(esc_letters[k], k[0]);
        end
        add_unit(CHAR_BACKSLASH, 1'b0);
        add_unit(16'hFFFF, 1'b1);
        add_unit(CHAR_BACKSLASH, 1'b0);
        add_unit(CHAR_X_LOWER, 1'b0);
        add_unit(16'h0041, 1'b1);
        add_unit(CHAR_BACKSLASH, 1'b0);
        add_unit(CHAR_U_LOWER, 1'b0);
        add_unit(16'h0000, 1'b0);
        add_unit(16'h0066, 1'b1);
        add_unit(CHAR_BACKSLASH, 1'b0);
        add_unit(CHAR_X_LOWER, 1'b1);
        add_unit(CHAR_BACKSLASH, 1'b1);
        add_unit(CHAR_BACKSLASH, 1'b0);
        add_unit(CHAR_X_LOWER, 1'b0);
        add_unit(16'h0039, 1'b0);
        add_unit(16'h0063, 1'b1);

        // Mostly well-formed strings with random content, some noise and truncated endings.
        target = stim_q.size() + RANDOM_ITEMS;
        while (stim_q.size() < target)
        begin
            first = stim_q.size();
            if ($urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, 4)) add_unit(16'($urandom), $urandom_range(3) == 0);
                continue;
            end
            repeat ($urandom_range(1, 6))
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    unit = $urandom_range(1) ? 16'($urandom_range(16'h0020, 16'h007E))
                                             : 16'($urandom);
                    add_unit(unit, 1'b0);
                end
                else if (pick < 50)
                begin
                    add_unit(CHAR_BACKSLASH, 1'b0);
                    add_unit(esc_letters[$urandom_range(6)], 1'b0);
                end
                else if (pick < 58)
                begin
                    add_unit(CHAR_BACKSLASH, 1'b0);
                    add_unit(16'($urandom), 1'b0);
                end
                else
                begin
                    ndig = (pick < 75) ? 2 : 4;
                    add_unit(CHAR_BACKSLASH, 1'b0);
                    add_unit((ndig == 2) ? CHAR_X_LOWER : CHAR_U_LOWER, 1'b0);
                    repeat (ndig)
                    begin
                        k = $urandom_range(21);
                        if ($urandom_range(9) == 0)
                        begin
                            unit = 16'($urandom);
                        end
                        else if (k < 10)
                        begin
                            unit = 16'h0030 + 16'(k);
                        end
                        else if (k < 16)
                        begin
                            unit = 16'h0041 + 16'(k - 10);
                        end
                        else
                        begin
                            unit = 16'h0061 + 16'(k - 16);
                        end
                        add_unit(unit, 1'b0);
                    end
                end
            end
            if ($urandom_range(99) < 12)
            begin
                drop = $urandom_range(1, 3);
                while (drop > 0 && stim_q.size() > first + 1)
                begin
                    void'(stim_q.pop_back());
                    drop--;
                end
            end
            stim_q[stim_q.size() - 1].is_last = 1'b1;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (sent < stim_q.size())
        begin
            @(posedge clk);
            if (text_valid && !text_stall)
            begin
                sent++;
            end
            if (!text_valid || !text_stall)
            begin
                if (sent < stim_q.size() && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    text_valid <= 1'b1;
                    text_item <= stim_q[sent];
                end
                else
                begin
                    text_valid <= 1'b0;
                end
            end
        end

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb_escape_sequence_decoder: clean");
        end
        else
        begin
            $display("tb_escape_sequence_decoder: errors");
        end
        $finish;
    end

endmodule
